/* design/cfsm_pkg.sv */
`default_nettype none

package cfsm_pkg;

  // Frame and command queue geometry.
  localparam int unsigned FRAME_SLOTS = 16;
  localparam int unsigned CMD_DEPTH   = 8;

  localparam int unsigned SLOT_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int unsigned PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
  localparam logic [SLOT_W-1:0] FLAG_SLOT = SLOT_W'(FRAME_SLOTS - 2);
  localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(CMD_DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CMD_DEPTH);

  localparam logic [15:0] SAMPLE_MASK = 16'hFFFE;
  localparam logic [15:0] FLAG_BIT    = 16'h0001;

  localparam int unsigned DEV_W = 3;

  typedef enum logic [1:0] {
    MODE_TX  = 2'd0,
    MODE_RX  = 2'd1,
    MODE_UPD = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic        sample_present;
    logic [15:0] tx_sample;
    logic [15:0] rx_word;
    logic [1:0]  reg_index;
    logic [7:0]  reg_value;
    logic [7:0]  reg_mask;
  } in_word_t;

  typedef struct packed {
    logic        tx_word_valid;
    logic [15:0] tx_word;
    logic        sample_taken;
    logic        rx_sample_valid;
    logic [15:0] rx_sample;
    logic        update_accepted;
  } out_word_t;

  // One queued register command: register number and new value.
  typedef struct packed {
    logic [1:0] reg_index;
    logic [7:0] value;
  } cmd_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    cmd_entry_t wdata;
  } queue_ctrl_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    cmd_entry_t rdata;
  } queue_stat_t;

endpackage

`default_nettype wire

/* design/cfsm_if.sv */
`default_nettype none

interface cfsm_in_if import cfsm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cfsm_out_if import cfsm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/cfsm_queue.sv */
`default_nettype none

module cfsm_queue import cfsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire queue_ctrl_t ctrl_i,
  output queue_stat_t      stat_o
);

  cmd_entry_t         mem_q [CMD_DEPTH];
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [COUNT_W-1:0] count_q, count_d;

  // Entry storage has no reset; the count keeps unwritten entries from being read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= ctrl_i.wdata;
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
      count_d = count_d + 1'b1;
    end
    if (ctrl_i.pop) begin
      head_d  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
      count_d = count_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign stat_o.full  = (count_q == FULL_COUNT);
  assign stat_o.empty = (count_q == '0);
  assign stat_o.rdata = mem_q[head_q];

endmodule

`default_nettype wire

/* design/cfsm_core.sv */
`default_nettype none

module cfsm_core import cfsm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [DEV_W-1:0] device_id_i,
  input  wire logic             accept_i,
  input  wire in_word_t         item_i,
  input  wire queue_stat_t      qstat_i,
  output queue_ctrl_t           qctrl_o,
  output out_word_t             result_o
);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [7:0]        shadow_q [4];
  logic [7:0]        new_value;
  logic [2:0]        sent_index;
  logic              shadow_we;

  assign new_value  = (shadow_q[item_i.reg_index] & ~item_i.reg_mask) |
                      (item_i.reg_value & item_i.reg_mask);
  assign sent_index = {1'b0, qstat_i.rdata.reg_index} + 3'd1;

  always_comb begin
    result_o  = '0;
    qctrl_o   = '0;
    slot_d    = slot_q;
    shadow_we = 1'b0;
    qctrl_o.wdata.reg_index = item_i.reg_index;
    qctrl_o.wdata.value     = new_value;
    case (mode_e'(item_i.mode))
      MODE_TX: begin
        result_o.tx_word_valid = 1'b1;
        if (slot_q == LAST_SLOT) begin
          // Command slot: oldest queued command, or zero.
          slot_d = '0;
          if (!qstat_i.empty) begin
            result_o.tx_word = {device_id_i, 1'b0, sent_index, 1'b0, qstat_i.rdata.value};
            qctrl_o.pop      = accept_i;
          end
        end else begin
          slot_d = slot_q + 1'b1;
          if (item_i.sample_present) begin
            result_o.tx_word      = item_i.tx_sample & SAMPLE_MASK;
            result_o.sample_taken = 1'b1;
          end
          if (slot_q == FLAG_SLOT) begin
            result_o.tx_word = result_o.tx_word | FLAG_BIT;
          end
        end
      end
      MODE_RX: begin
        if (item_i.rx_word[0]) begin
          result_o.rx_sample_valid = 1'b1;
          result_o.rx_sample       = item_i.rx_word & SAMPLE_MASK;
        end
      end
      MODE_UPD: begin
        shadow_we = accept_i;
        if (!qstat_i.full) begin
          qctrl_o.push             = accept_i;
          result_o.update_accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      shadow_q <= '{default: '0};
    end else if (accept_i) begin
      slot_q <= slot_d;
      if (shadow_we) begin
        shadow_q[item_i.reg_index] <= new_value;
      end
    end
  end

endmodule

`default_nettype wire

/* design/codec_frame_slot_mux_top.sv */
`default_nettype none

// A result word is registered: it appears the cycle after its input is accepted.
// Throughput: one word per cycle unless out_o.ready stalls; a new word is taken
// while the previous result is being taken; the result register is the only stage.
// Reset (asynchronous, active low) clears the slot counter, shadow registers,
// queue pointers and device ID; queue entries are left as they were.

module codec_frame_slot_mux_top import cfsm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [DEV_W-1:0] cfg_wdata_i,
  cfsm_in_if.sink               in_i,
  cfsm_out_if.source            out_o
);

  logic [DEV_W-1:0] device_id_q;
  logic             accept;
  logic             out_valid_q;
  out_word_t        out_word_q;
  out_word_t        result;
  queue_ctrl_t      qctrl;
  queue_stat_t      qstat;

  // The device ID is sampled when a command goes out, not when it is queued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= '0;
    end else if (cfg_we_i) begin
      device_id_q <= cfg_wdata_i;
    end
  end

  // Take a new word whenever the result register is empty or is being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  cfsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .device_id_i (device_id_q),
    .accept_i    (accept),
    .item_i      (in_i.data),
    .qstat_i     (qstat),
    .qctrl_o     (qctrl),
    .result_o    (result)
  );

  cfsm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (qctrl),
    .stat_o (qstat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule

`default_nettype wire
